// ===== rtl/sphsv_pkg.sv =====
package sphsv_pkg;

    // field widths
    localparam int unsigned FIX_W    = 32;
    localparam int unsigned DIFF_W   = 33;
    localparam int unsigned PROD_W   = 66;
    localparam int unsigned ACC_W    = 67;
    localparam int unsigned R2_W     = 68;
    localparam int unsigned ROOT_W   = 34;
    localparam int unsigned SIG_W    = 36;

    // saturation value of the signal speed
    localparam logic [SIG_W-1:0] SIG_MAX = {SIG_W{1'b1}};

    // item operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_NEIGHBOR = 1'b1;

    // formula modes
    localparam logic MODE_FULL = 1'b0;
    localparam logic MODE_HALF = 1'b1;

endpackage

// ===== rtl/sphsv_if.sv =====
interface sphsv_in_if;
    import sphsv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [FIX_W-1:0]        particle_id;
    logic signed [FIX_W-1:0] pos_x;
    logic signed [FIX_W-1:0] pos_y;
    logic signed [FIX_W-1:0] pos_z;
    logic signed [FIX_W-1:0] vel_x;
    logic signed [FIX_W-1:0] vel_y;
    logic signed [FIX_W-1:0] vel_z;
    logic [FIX_W-1:0]        sound_speed;
    logic                    last_item;

    modport source (
        output valid, operation, particle_id, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, sound_speed, last_item,
        input  ready
    );
    modport sink (
        input  valid, operation, particle_id, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, sound_speed, last_item,
        output ready
    );
endinterface

interface sphsv_out_if;
    import sphsv_pkg::*;

    logic             valid;
    logic             ready;
    logic [SIG_W-1:0] signal_speed;

    modport source (output valid, signal_speed, input ready);
    modport sink   (input valid, signal_speed, output ready);
endinterface

// ===== rtl/sphsv_isqrt.sv =====
module sphsv_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sphsv_pkg::R2_W-1:0]    i_radicand,
    output logic                          o_done,
    output logic [sphsv_pkg::ROOT_W-1:0]  o_root
);
    import sphsv_pkg::*;

    localparam int unsigned REM_W = ROOT_W + 2;
    localparam int unsigned CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [R2_W-1:0]   r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  c_sh;
    logic [REM_W+1:0]  c_trial;
    logic              c_ge;

    // one result bit per step: bring down two radicand bits, trial subtract
    always_comb begin
        c_sh    = {r_rem, r_x[R2_W-1 -: 2]};
        c_trial = {2'b00, r_root, 2'b01};
        c_ge    = (c_sh >= c_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x <= {r_x[R2_W-3:0], 2'b00};
                if (c_ge) begin
                    r_rem  <= REM_W'(c_sh - c_trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= c_sh[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== rtl/sph_signal_velocity_max.sv =====
// load item: taken in the idle state, which the block does not leave, so ready stays high
// neighbor item: from accept, ready stays low through the shared 33x33 multiplier, the
//   bit-serial square root, the bit-serial divider when w needs it, the candidate update
//   (skipped on a self pair) and, on a last item, the emit step, which waits while the output stalls
// one item in flight; a finished result waits in the output register
// synchronous active-low reset clears target state, maximum, mode and output valid
module sph_signal_velocity_max (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    sphsv_in_if.sink    i_in,
    sphsv_out_if.source o_out
);
    import sphsv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_SQRT, ST_DIV, ST_CAND, ST_EMIT
    } t_state;

    localparam int unsigned QBITS = SIG_W;
    localparam int unsigned REM_W = ROOT_W;

    t_state                     r_state;
    logic                       r_mode;
    logic [FIX_W-1:0]           r_tgt_id;
    logic signed [FIX_W-1:0]    r_tgt_pos [3];
    logic signed [FIX_W-1:0]    r_tgt_vel [3];
    logic [FIX_W-1:0]           r_tgt_cs;
    logic [SIG_W-1:0]           r_max;

    logic [FIX_W-1:0]           r_nb_id;
    logic [FIX_W-1:0]           r_nb_cs;
    logic                       r_nb_last;
    logic [DIFF_W-1:0]          r_mx [3];
    logic [DIFF_W-1:0]          r_mv [3];
    logic                       r_sgn [3];
    logic [2:0]                 r_step;
    logic [PROD_W-1:0]          r_prod;
    logic [R2_W-1:0]            r_r2;
    logic [ACC_W-1:0]           r_pos;
    logic [ACC_W-1:0]           r_neg;
    logic [ACC_W-1:0]           r_diff;
    logic                       r_wneg;
    logic [ROOT_W-1:0]          r_root;
    logic [REM_W-1:0]           r_rem;
    logic [QBITS-1:0]           r_num;
    logic [5:0]                 r_cnt;
    logic [SIG_W-1:0]           r_wmag;
    logic                       r_out_valid;
    logic [SIG_W-1:0]           r_out_data;

    logic signed [DIFF_W-1:0]   c_dx [3];
    logic signed [DIFF_W-1:0]   c_dv [3];
    logic signed [FIX_W-1:0]    c_in_pos [3];
    logic signed [FIX_W-1:0]    c_in_vel [3];
    logic [1:0]                 c_idx;
    logic [2:0]                 c_prev;
    logic [1:0]                 c_pidx;
    logic [DIFF_W-1:0]          c_ma;
    logic [DIFF_W-1:0]          c_mb;
    logic                       c_sq_start;
    logic                       c_sq_done;
    logic [ROOT_W-1:0]          c_sq_root;
    logic [REM_W:0]             c_dt;
    logic                       c_dge;
    logic [FIX_W:0]             c_sum;
    logic [SIG_W+2:0]           c_cand_full;
    logic [SIG_W:0]             c_cand_half;
    logic [SIG_W-1:0]           c_cand;
    logic                       c_accept;
    logic                       c_out_free;

    assign c_accept   = i_in.valid && i_in.ready;
    assign c_out_free = !r_out_valid || o_out.ready;

    // differences and their magnitudes at accept
    always_comb begin
        c_in_pos[0] = i_in.pos_x;
        c_in_pos[1] = i_in.pos_y;
        c_in_pos[2] = i_in.pos_z;
        c_in_vel[0] = i_in.vel_x;
        c_in_vel[1] = i_in.vel_y;
        c_in_vel[2] = i_in.vel_z;
        for (int k = 0; k < 3; k++) begin
            c_dx[k] = DIFF_W'(r_tgt_pos[k]) - DIFF_W'(c_in_pos[k]);
            c_dv[k] = DIFF_W'(r_tgt_vel[k]) - DIFF_W'(c_in_vel[k]);
        end
    end

    // shared multiplier operand select: three squares, then three cross terms
    always_comb begin
        c_idx  = (r_step < 3'd3) ? r_step[1:0] : 2'(r_step - 3'd3);
        c_ma   = r_mx[c_idx];
        c_mb   = (r_step < 3'd3) ? r_mx[c_idx] : r_mv[c_idx];
        c_prev = r_step - 3'd1;
        c_pidx = 2'(c_prev - 3'd3);
    end

    assign c_sq_start = (r_state == ST_MUL) && (r_step == 3'd6);

    sphsv_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_sq_start),
        .i_radicand (r_r2),
        .o_done     (c_sq_done),
        .o_root     (c_sq_root)
    );

    // divider step: bring down one numerator bit, trial subtract the distance
    always_comb begin
        c_dt  = {r_rem, r_num[QBITS-1]};
        c_dge = (c_dt >= {1'b0, r_root});
    end

    // candidate signal speed with saturation
    always_comb begin
        c_sum       = {1'b0, r_tgt_cs} + {1'b0, r_nb_cs};
        c_cand_full = (SIG_W+3)'(c_sum) + (SIG_W+3)'({r_wmag, 1'b0}) + (SIG_W+3)'(r_wmag);
        c_cand_half = (SIG_W+1)'(c_sum[FIX_W:1]) + (SIG_W+1)'(r_wmag);
        if (r_mode == MODE_FULL) begin
            c_cand = (c_cand_full > (SIG_W+3)'(SIG_MAX)) ? SIG_MAX : c_cand_full[SIG_W-1:0];
        end else begin
            c_cand = (c_cand_half > (SIG_W+1)'(SIG_MAX)) ? SIG_MAX : c_cand_half[SIG_W-1:0];
        end
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_FULL;
            r_tgt_id    <= '0;
            r_tgt_cs    <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_tgt_pos[k] <= '0;
                r_tgt_vel[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            // the emit step sets valid itself
            if (r_out_valid && o_out.ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (c_accept && i_in.operation == OP_LOAD) begin
                        r_tgt_id <= i_in.particle_id;
                        r_tgt_cs <= i_in.sound_speed;
                        r_max    <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_tgt_pos[k] <= c_in_pos[k];
                            r_tgt_vel[k] <= c_in_vel[k];
                        end
                    end else if (c_accept) begin
                        r_nb_id   <= i_in.particle_id;
                        r_nb_cs   <= i_in.sound_speed;
                        r_nb_last <= i_in.last_item;
                        for (int k = 0; k < 3; k++) begin
                            r_mx[k]  <= c_dx[k][DIFF_W-1] ? DIFF_W'(-c_dx[k])
                                                          : DIFF_W'(c_dx[k]);
                            r_mv[k]  <= c_dv[k][DIFF_W-1] ? DIFF_W'(-c_dv[k])
                                                          : DIFF_W'(c_dv[k]);
                            r_sgn[k] <= c_dx[k][DIFF_W-1] ^ c_dv[k][DIFF_W-1];
                        end
                        r_step  <= '0;
                        r_r2    <= '0;
                        r_pos   <= '0;
                        r_neg   <= '0;
                        r_state <= ST_MUL;
                    end
                end

                ST_MUL: begin
                    r_prod <= c_ma * c_mb;
                    // accumulate the previous product
                    if (r_step != 3'd0) begin
                        if (c_prev < 3'd3) begin
                            r_r2 <= r_r2 + R2_W'(r_prod);
                        end else if (r_sgn[c_pidx]) begin
                            r_neg <= r_neg + ACC_W'(r_prod);
                        end else begin
                            r_pos <= r_pos + ACC_W'(r_prod);
                        end
                    end
                    if (r_step == 3'd6) begin
                        r_state <= ST_SQRT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end

                ST_SQRT: begin
                    r_diff <= r_neg - r_pos;
                    r_wneg <= (r_neg > r_pos);
                    if (c_sq_done) begin
                        r_root <= c_sq_root;
                        if (r_nb_id == r_tgt_id && c_sq_root == '0) begin
                            // self pair: maximum unchanged
                            r_wmag  <= '0;
                            r_state <= r_nb_last ? ST_EMIT : ST_IDLE;
                        end else if (r_wneg && c_sq_root != '0) begin
                            if ((ACC_W+1)'(r_diff[ACC_W-1:QBITS]) >= (ACC_W+1)'(c_sq_root))
                            begin
                                r_wmag  <= SIG_MAX;
                                r_state <= ST_CAND;
                            end else begin
                                r_wmag  <= '0;
                                r_rem   <= REM_W'(r_diff[ACC_W-1:QBITS]);
                                r_num   <= r_diff[QBITS-1:0];
                                r_cnt   <= 6'(QBITS - 1);
                                r_state <= ST_DIV;
                            end
                        end else begin
                            r_wmag  <= '0;
                            r_state <= ST_CAND;
                        end
                    end
                end

                ST_DIV: begin
                    r_num  <= {r_num[QBITS-2:0], 1'b0};
                    r_wmag <= {r_wmag[SIG_W-2:0], c_dge};
                    r_rem  <= c_dge ? REM_W'(c_dt - {1'b0, r_root}) : c_dt[REM_W-1:0];
                    if (r_cnt == '0) begin
                        r_state <= ST_CAND;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end

                ST_CAND: begin
                    if (c_cand > r_max) begin
                        r_max <= c_cand;
                    end
                    r_state <= r_nb_last ? ST_EMIT : ST_IDLE;
                end

                ST_EMIT: begin
                    if (c_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_max;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.signal_speed = r_out_data;

    // maximum only falls on a load item
    a_max_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(c_accept && i_in.operation == OP_LOAD) |=> r_max >= $past(r_max))
        else $error("running maximum decreased without a load");

    // square root finishes only while the sequencer waits for it
    a_sqrt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_sq_done |-> r_state == ST_SQRT)
        else $error("square root done outside its wait state");

    // a new result appears only out of the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result raised outside emit");

    // divider count stays in range
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt < 6'(QBITS))
        else $error("divider count out of range");
endmodule

// ===== tb/sph_signal_velocity_max_tb.sv =====
module sph_signal_velocity_max_tb;
    import sphsv_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int DRAIN_WAIT  = 100;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 190;

    typedef struct {
        logic                    mode;
        logic                    operation;
        logic [FIX_W-1:0]        particle_id;
        logic signed [FIX_W-1:0] pos [3];
        logic signed [FIX_W-1:0] vel [3];
        logic [FIX_W-1:0]        sound_speed;
        logic                    last_item;
        logic                    has_known;
        logic [SIG_W-1:0]        known_speed;
    } t_particle_item;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    sphsv_in_if  in_if ();
    sphsv_out_if out_if ();

    sph_signal_velocity_max uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // shadow copy of the target state and the formula mode
    logic                    mode_shadow;
    logic [FIX_W-1:0]        tgt_id;
    logic signed [FIX_W-1:0] tgt_pos [3];
    logic signed [FIX_W-1:0] tgt_vel [3];
    logic [FIX_W-1:0]        tgt_cs;
    logic [SIG_W-1:0]        max_speed;

    logic [SIG_W-1:0] speed_queue [$];
    int               item_count;
    int               result_count;
    int               error_count;
    int               quiet_cycles;
    bit               no_idle;
    int               ready_stall;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // predictor for one accepted item
    function automatic void predict_speed(input t_particle_item it);
        logic signed [32:0] dx;
        logic signed [32:0] dv;
        logic signed [67:0] sq;
        logic signed [67:0] pr;
        logic signed [67:0] dot;
        logic [67:0]        r2;
        logic [34:0]        root;
        logic [34:0]        c;
        logic [69:0]        cw;
        logic [67:0]        quo;
        logic [SIG_W-1:0]   wmag;
        logic [39:0]        cand;
        logic [39:0]        sum;
        if (it.operation == OP_LOAD) begin
            tgt_id    = it.particle_id;
            tgt_pos   = it.pos;
            tgt_vel   = it.vel;
            tgt_cs    = it.sound_speed;
            max_speed = '0;
            return;
        end
        r2  = '0;
        dot = '0;
        for (int k = 0; k < 3; k++) begin
            dx  = tgt_pos[k] - it.pos[k];
            dv  = tgt_vel[k] - it.vel[k];
            sq  = dx * dx;
            pr  = dx * dv;
            r2  = r2 + sq;
            dot = dot + pr;
        end
        // bitwise integer square root
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            c  = root | (35'd1 << b);
            cw = c;
            if (cw * cw <= {2'b00, r2}) root = c;
        end
        if (!(it.particle_id == tgt_id && root == 0)) begin
            wmag = '0;
            if (dot < 0 && root != 0) begin
                quo  = 68'(-dot) / 68'(root);
                wmag = (quo > 68'(SIG_MAX)) ? SIG_MAX : quo[SIG_W-1:0];
            end
            sum = 40'(tgt_cs) + 40'(it.sound_speed);
            if (mode_shadow == MODE_FULL) cand = sum + 40'(wmag) * 40'd3;
            else cand = (sum >> 1) + 40'(wmag);
            if (cand > 40'(SIG_MAX)) cand = 40'(SIG_MAX);
            if (cand[SIG_W-1:0] > max_speed) max_speed = cand[SIG_W-1:0];
        end
        if (it.last_item) speed_queue.push_back(max_speed);
    endfunction

    // pick a gap length: mostly short, sometimes long
    function automatic int pick_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // drive one item and wait for its handshake
    task automatic send_item(input t_particle_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= it.operation;
        in_if.particle_id <= it.particle_id;
        in_if.pos_x       <= it.pos[0];
        in_if.pos_y       <= it.pos[1];
        in_if.pos_z       <= it.pos[2];
        in_if.vel_x       <= it.vel[0];
        in_if.vel_y       <= it.vel[1];
        in_if.vel_z       <= it.vel[2];
        in_if.sound_speed <= it.sound_speed;
        in_if.last_item   <= it.last_item;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        item_count++;
        predict_speed(it);
        if (it.has_known && it.last_item && speed_queue.size() > 0 &&
            speed_queue[$] !== it.known_speed) begin
            $display("%0t: predictor disagrees with table: expected %h, actual %h",
                     $time, it.known_speed, speed_queue[$]);
            error_count++;
        end
    endtask

    // wait for the block to go idle, then write the mode register
    task automatic set_mode(input logic m);
        in_if.valid <= 1'b0;
        while (speed_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mode_shadow = m;
    endtask

    function automatic t_particle_item make_item(input logic op, input logic [31:0] id,
                                                 input logic [31:0] px,
                                                 input logic [31:0] vx,
                                                 input logic [31:0] cs,
                                                 input logic last);
        t_particle_item it;
        it.mode        = mode_shadow;
        it.operation   = op;
        it.particle_id = id;
        it.pos         = '{px, 0, 0};
        it.vel         = '{vx, 0, 0};
        it.sound_speed = cs;
        it.last_item   = last;
        it.has_known   = 1'b0;
        it.known_speed = '0;
        return it;
    endfunction

    // random neighbor, mostly close to the target so that w is active
    function automatic t_particle_item rand_neighbor(input logic last);
        t_particle_item it;
        it = make_item(OP_NEIGHBOR, $urandom, 0, 0, $urandom, last);
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int k = 0; k < 3; k++) begin
                    it.pos[k] = $urandom;
                    it.vel[k] = $urandom;
                end
            end
            2: begin
                it.particle_id = tgt_id;
                it.pos         = tgt_pos;
                for (int k = 0; k < 3; k++) it.vel[k] = $urandom;
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    it.pos[k] = tgt_pos[k] + $signed(32'($urandom_range(0, 'h3ffff)) - 'h20000);
                    it.vel[k] = tgt_vel[k] + $signed(32'($urandom) >>> $urandom_range(0, 20));
                end
            end
        endcase
        if ($urandom_range(0, 3) == 0) it.sound_speed = $urandom_range(0, 'hfffff);
        return it;
    endfunction

    // output side: random ready stalls and result check
    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            result_count++;
            if (speed_queue.size() == 0) begin
                $display("%0t: unexpected signal speed, expected none, actual %h",
                         $time, out_if.signal_speed);
                error_count++;
            end else begin
                if (out_if.signal_speed !== speed_queue[0]) begin
                    $display("%0t: signal speed mismatch, expected %h, actual %h",
                             $time, speed_queue[0], out_if.signal_speed);
                    error_count++;
                end
                void'(speed_queue.pop_front());
            end
        end
        if (ready_stall > 0) begin
            ready_stall--;
            out_if.ready <= 1'b0;
        end else if (no_idle || $urandom_range(0, 3) != 0) begin
            out_if.ready <= 1'b1;
        end else begin
            ready_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("sph_signal_velocity_max verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_particle_item dir_rows [$];
        t_particle_item it;
        int             nbrs;

        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        in_if.valid       = 1'b0;
        in_if.operation   = OP_LOAD;
        in_if.particle_id = '0;
        in_if.pos_x       = '0;
        in_if.pos_y       = '0;
        in_if.pos_z       = '0;
        in_if.vel_x       = '0;
        in_if.vel_y       = '0;
        in_if.vel_z       = '0;
        in_if.sound_speed = '0;
        in_if.last_item   = 1'b0;
        out_if.ready      = 1'b0;
        item_count   = 0;
        result_count = 0;
        error_count  = 0;
        quiet_cycles = 0;
        ready_stall  = 0;
        no_idle      = 1'b0;
        mode_shadow  = MODE_FULL;
        tgt_id       = '0;
        tgt_pos      = '{0, 0, 0};
        tgt_vel      = '{0, 0, 0};
        tgt_cs       = '0;
        max_speed    = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        // neighbor before any load, self pair against the zero target
        it = make_item(OP_NEIGHBOR, 0, 0, 0, 0, 1);
        it.has_known = 1; it.known_speed = 0; dir_rows.push_back(it);
        // neighbor before load with a distinct id: only sound speeds count
        it = make_item(OP_NEIGHBOR, 1, 32'h10000, 0, 32'h30000, 1);
        it.has_known = 1; it.known_speed = 36'h30000; dir_rows.push_back(it);
        // load with last set emits nothing
        it = make_item(OP_LOAD, 5, 0, 0, 32'h10000, 1); dir_rows.push_back(it);
        // skipped self pair still emits the cleared maximum
        it = make_item(OP_NEIGHBOR, 5, 0, 0, 32'hffffffff, 1);
        it.has_known = 1; it.known_speed = 0; dir_rows.push_back(it);
        // receding pair: w is zero
        it = make_item(OP_NEIGHBOR, 6, 32'h10000, 32'h10000, 32'h10000, 0); dir_rows.push_back(it);
        // same id at nonzero distance is not skipped; approaching pair
        it = make_item(OP_NEIGHBOR, 5, 32'h10000, 32'hffff0000, 32'h10000, 1);
        dir_rows.push_back(it);
        // maximum kept after emission
        it = make_item(OP_NEIGHBOR, 7, 32'h20000, 0, 0, 1); dir_rows.push_back(it);
        // extremes of position, velocity and sound speed
        it = make_item(OP_LOAD, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0);
        it.pos = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        it.vel = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        dir_rows.push_back(it);
        it = make_item(OP_NEIGHBOR, 0, 0, 0, 32'hffffffff, 0);
        it.pos = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        it.vel = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        dir_rows.push_back(it);
        it = make_item(OP_NEIGHBOR, 0, 0, 0, 32'hffffffff, 1);
        it.pos = '{32'h7ffffffe, 32'h80000000, 32'h7fffffff};
        it.vel = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        dir_rows.push_back(it);
        // one ulp apart with a huge closing speed
        it = make_item(OP_LOAD, 9, 0, 32'h80000000, 0, 0); dir_rows.push_back(it);
        it = make_item(OP_NEIGHBOR, 10, 32'hffffffff, 32'h7fffffff, 0, 1); dir_rows.push_back(it);
        // same rows again in half-sum mode, now on top of the previous target
        for (int i = 0; i < 12; i++) begin
            it = dir_rows[i];
            it.mode = MODE_HALF;
            it.has_known = 1'b0;
            dir_rows.push_back(it);
        end

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != mode_shadow) set_mode(dir_rows[i].mode);
            send_item(dir_rows[i]);
        end

        // random phases, alternating formula mode
        for (int ph = 0; ph < PHASES; ph++) begin
            set_mode((ph % 2 == 0) ? MODE_FULL : MODE_HALF);
            no_idle = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; ) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: free-running item with random op and last flag
                    it = rand_neighbor($urandom_range(0, 1));
                    it.operation = $urandom_range(0, 1);
                    send_item(it);
                    n++;
                end else begin
                    it = make_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 1));
                    for (int k = 0; k < 3; k++) begin
                        it.pos[k] = $urandom;
                        it.vel[k] = $urandom;
                    end
                    if ($urandom_range(0, 2) == 0) it.sound_speed = $urandom_range(0, 'hfffff);
                    send_item(it);
                    nbrs = $urandom_range(1, 6);
                    for (int j = 0; j < nbrs; j++) send_item(rand_neighbor(j == nbrs - 1));
                    n += nbrs + 1;
                end
            end
        end

        in_if.valid <= 1'b0;
        while (speed_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d items sent (loads, neighbors, self pairs, noise), %0d speeds checked",
                 item_count, result_count);
        $display("both formula modes exercised with random stalls on input and output");
        if (error_count == 0) begin
            $display("sph_signal_velocity_max verification clean");
        end else begin
            $display("sph_signal_velocity_max verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sphsv_pkg.sv
rtl/sphsv_if.sv
rtl/sphsv_isqrt.sv
rtl/sph_signal_velocity_max.sv
tb/sph_signal_velocity_max_tb.sv
